// File: rtl/core/fdre_pkg.sv
package fdre_pkg;

    localparam int unsigned PageSizeDef = 1024;
    localparam int unsigned MaxRunDef   = 60;

    // byte kinds on the result stream
    localparam logic [2:0] KIND_LEN    = 3'd0;
    localparam logic [2:0] KIND_OFF_LO = 3'd1;
    localparam logic [2:0] KIND_OFF_HI = 3'd2;
    localparam logic [2:0] KIND_DATA   = 3'd3;
    localparam logic [2:0] KIND_TERM   = 3'd4;

    localparam logic [7:0] TERM_BYTE = 8'hff;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       load;
        logic [2:0] kind;
        logic       last;
        logic       rd_inc;
        logic       rd_clr;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic eop;
        logic out_free;
        logic data_last;
    } status_t;

    // rotate each nibble right by one bit
    function automatic logic [7:0] rot_byte(input logic [7:0] b);
        rot_byte = {b[4], b[7:5], b[0], b[3:1]};
    endfunction

endpackage

// File: rtl/core/frame_delta_run_encoder_unit.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata: old_byte, new_byte; tlast: end_of_page
// m_        out  m_tvalid/m_tready    tdata: out_byte; tuser: byte_kind; tlast: last
// cfg_      in   cfg_valid/cfg_ready  cfg_data: rotate_nibbles
//
// a word that closes no run and ends no page leaves s_tready high for the next word
// a word that closes a run is followed by its length, offset low/high and data bytes, plus
// the terminator at end of page; emit speed is one word per cycle while m_ is not stalled
// input is held off (s_tready low) while a record is being emitted
// aresetn is synchronous, active low; the run byte buffer needs no clearing
// a stalled m_ side holds the result register and freezes the emit sequence
module frame_delta_run_encoder_unit #(
    parameter int unsigned PAGE_SIZE = fdre_pkg::PageSizeDef,
    parameter int unsigned MAX_RUN   = fdre_pkg::MaxRunDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] old_byte, [15:8] new_byte
    input  logic        s_tlast,   // end_of_page
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] byte_kind
    output logic        m_tlast,   // last word caused by the input word
    // rotate_nibbles register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    fdre_pkg::cmd_t    cmd;
    fdre_pkg::status_t status;

    // config register is always writable
    assign cfg_ready = 1'b1;

    // sequencer: accept, then length, offset low/high, data bytes, terminator
    fdre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // run tracking, byte buffer and result register
    fdre_datapath #(
        .PAGE_SIZE (PAGE_SIZE),
        .MAX_RUN   (MAX_RUN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/core/fdre_ctrl.sv
module fdre_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fdre_pkg::status_t status,
    output fdre_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LEN    = 3'd1;
    localparam logic [2:0] ST_OFF_LO = 3'd2;
    localparam logic [2:0] ST_OFF_HI = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;
    localparam logic [2:0] ST_TERM   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       term_reg, term_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    term_next = status.eop;
                    if (status.emit) begin
                        state_next = ST_LEN;
                    end else if (status.eop) begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_LEN: begin
                cmd.kind = fdre_pkg::KIND_LEN;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_OFF_LO;
                end
            end
            ST_OFF_LO: begin
                cmd.kind = fdre_pkg::KIND_OFF_LO;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_OFF_HI;
                end
            end
            ST_OFF_HI: begin
                cmd.kind = fdre_pkg::KIND_OFF_HI;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                cmd.kind = fdre_pkg::KIND_DATA;
                cmd.last = status.data_last && !term_reg;
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.data_last) begin
                        cmd.rd_clr = 1'b1;
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        cmd.rd_inc = 1'b1;
                    end
                end
            end
            ST_TERM: begin
                cmd.kind = fdre_pkg::KIND_TERM;
                cmd.last = 1'b1;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

endmodule

// File: rtl/core/fdre_datapath.sv
module fdre_datapath #(
    parameter int unsigned PAGE_SIZE = fdre_pkg::PageSizeDef,
    parameter int unsigned MAX_RUN   = fdre_pkg::MaxRunDef
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fdre_pkg::cmd_t    cmd,
    output fdre_pkg::status_t status,
    input  logic [15:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    localparam int unsigned PW = $clog2(PAGE_SIZE);
    localparam int unsigned CW = $clog2(MAX_RUN + 1);
    localparam int unsigned IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic          in_run_reg, in_run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rot_reg;

    logic [7:0]    len_reg;
    logic [15:0]   dist_reg;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    rd_data_reg;
    logic [7:0]    mem [MAX_RUN];

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [2:0]    out_kind_reg;
    logic          out_last_reg;

    logic [7:0]    old_b, new_b;
    logic          diff;
    logic [PW-1:0] start_eff;
    logic [CW-1:0] cnt_base, cnt_inc, emit_len;
    logic          emit;
    logic [16:0]   dist_full;
    logic [7:0]    out_mux;

    assign old_b     = s_tdata[7:0];
    assign new_b     = s_tdata[15:8];
    assign diff      = (old_b != new_b);
    assign start_eff = in_run_reg ? cur_reg : pos_reg;
    assign cnt_base  = in_run_reg ? cnt_reg : '0;
    assign cnt_inc   = cnt_base + CW'(1);
    assign emit_len  = diff ? cnt_inc : cnt_reg;
    // full run, run broken by an equal byte, or run still open at end of page
    assign emit      = (diff && (cnt_inc == CW'(MAX_RUN))) || (!diff && in_run_reg)
                       || (diff && s_tlast);
    assign dist_full = 17'(start_eff) - 17'(prev_reg);

    assign status.emit      = emit;
    assign status.eop       = s_tlast;
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.data_last = (len_reg == (8'(rd_idx_reg) + 8'd1));

    always_comb begin
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        in_run_next = in_run_reg;
        cnt_next    = cnt_reg;
        if (cmd.accept) begin
            if (s_tlast) begin
                pos_next    = '0;
                prev_next   = '0;
                cur_next    = '0;
                in_run_next = 1'b0;
                cnt_next    = '0;
            end else begin
                pos_next = (pos_reg == PW'(PAGE_SIZE - 1)) ? '0 : pos_reg + PW'(1);
                if (emit) begin
                    prev_next   = start_eff;
                    in_run_next = 1'b0;
                    cnt_next    = '0;
                end else if (diff) begin
                    cur_next    = start_eff;
                    in_run_next = 1'b1;
                    cnt_next    = cnt_inc;
                end
            end
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clr) begin
            rd_idx_next = '0;
        end else if (cmd.rd_inc) begin
            rd_idx_next = rd_idx_reg + IW'(1);
        end
    end

    always_comb begin
        case (cmd.kind)
            fdre_pkg::KIND_LEN:    out_mux = len_reg;
            fdre_pkg::KIND_OFF_LO: out_mux = dist_reg[7:0];
            fdre_pkg::KIND_OFF_HI: out_mux = dist_reg[15:8];
            fdre_pkg::KIND_DATA:   out_mux = rot_reg ? fdre_pkg::rot_byte(rd_data_reg)
                                                     : rd_data_reg;
            default:               out_mux = fdre_pkg::TERM_BYTE;
        endcase
    end

    // run byte buffer; read data always follows the read index
    always_ff @(posedge aclk) begin
        if (cmd.accept && diff) begin
            mem[cnt_base[IW-1:0]] <= new_b;
        end
        rd_data_reg <= mem[rd_idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && emit) begin
            len_reg  <= 8'(emit_len);
            dist_reg <= dist_full[15:0];
        end
        if (cmd.load) begin
            out_byte_reg <= out_mux;
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            in_run_reg    <= 1'b0;
            cnt_reg       <= '0;
            rot_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            cur_reg    <= cur_next;
            in_run_reg <= in_run_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            if (cfg_valid) begin
                rot_reg <= cfg_data;
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned PageSize     = fdre_pkg::PageSizeDef;
    localparam int unsigned MaxRun       = fdre_pkg::MaxRunDef;
    // a word that closes no run and ends no page is done in the cycle after it is taken
    localparam int          SettleCycles = 8;

    // one word of the encoded stream as it should appear on the m_ side
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } enc_word_t;

    // tracks the page position and the open run, and queues the stream words each
    // accepted input word must produce
    class delta_rle_scoreboard;
        bit          rotate_nib;
        logic [15:0] page_pos;
        logic [15:0] prev_start;
        logic [15:0] open_start;
        bit          run_open;
        int unsigned run_len;
        logic [7:0]  run_buf[MaxRun];
        enc_word_t   expected_words[$];
        int          errors;
        int          reported;

        function new();
            rotate_nib = 1'b0;
            page_pos   = '0;
            prev_start = '0;
            open_start = '0;
            run_open   = 1'b0;
            run_len    = 0;
            errors     = 0;
            reported   = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (reported < 10) begin
                $display("%s", msg);
                reported++;
            end
        endfunction

        function void set_rotate(bit v);
            rotate_nib = v;
        endfunction

        // aux plane coding: each nibble turned right by one bit
        function logic [7:0] ror_nibbles(logic [7:0] b);
            logic [3:0] hi;
            logic [3:0] lo;
            hi = b[7:4];
            lo = b[3:0];
            return {hi[0], hi[3:1], lo[0], lo[3:1]};
        endfunction

        function void push_word(logic [7:0] d, logic [2:0] k);
            enc_word_t w;
            w.data = d;
            w.kind = k;
            w.last = 1'b0;
            expected_words.push_back(w);
        endfunction

        function void close_run();
            logic [15:0] run_dist;
            int          k;
            run_dist = open_start - prev_start;
            push_word(8'(run_len), fdre_pkg::KIND_LEN);
            push_word(run_dist[7:0], fdre_pkg::KIND_OFF_LO);
            push_word(run_dist[15:8], fdre_pkg::KIND_OFF_HI);
            for (k = 0; k < int'(run_len); k++)
                push_word(rotate_nib ? ror_nibbles(run_buf[k]) : run_buf[k],
                          fdre_pkg::KIND_DATA);
            prev_start = open_start;
            run_open   = 1'b0;
            run_len    = 0;
        endfunction

        function void note_word(logic [7:0] old_b, logic [7:0] new_b, bit eop);
            int        first;
            enc_word_t w;
            first = expected_words.size();
            if (old_b != new_b) begin
                if (!run_open) begin
                    run_open   = 1'b1;
                    open_start = page_pos;
                    run_len    = 0;
                end
                if (run_len < MaxRun)
                    run_buf[run_len] = new_b;
                run_len++;
                if (run_len >= MaxRun)
                    close_run();
            end else if (run_open) begin
                close_run();
            end
            if (page_pos == 16'(PageSize - 1))
                page_pos = '0;
            else
                page_pos = page_pos + 16'd1;
            if (eop) begin
                if (run_open)
                    close_run();
                push_word(fdre_pkg::TERM_BYTE, fdre_pkg::KIND_TERM);
                page_pos   = '0;
                prev_start = '0;
                open_start = '0;
                run_open   = 1'b0;
                run_len    = 0;
            end
            if (expected_words.size() > first) begin
                w = expected_words.pop_back();
                w.last = 1'b1;
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(logic [7:0] d, logic [2:0] k, logic l);
            enc_word_t w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word: byte %02h kind %0d last %0b", d, k, l));
            end else begin
                w = expected_words.pop_front();
                if (w.data !== d || w.kind !== k || w.last !== l)
                    report($sformatf({"mismatch: expected byte %02h kind %0d last %0b, ",
                                      "got byte %02h kind %0d last %0b"},
                                     w.data, w.kind, w.last, d, k, l));
            end
        endfunction

        function void flush_missing();
            enc_word_t w;
            while (expected_words.size() > 0) begin
                w = expected_words.pop_front();
                report($sformatf("missing word: byte %02h kind %0d last %0b",
                                 w.data, w.kind, w.last));
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] old_byte, [15:8] new_byte
    logic        s_tlast   = 1'b0; // end_of_page
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic [2:0]  m_tuser;          // [2:0] byte_kind
    logic        m_tlast;          // last word caused by the input word
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0; // rotate_nibbles

    delta_rle_scoreboard sb = new();

    // when set, neither side inserts gaps or stalls
    bit no_idle     = 1'b0;
    int words_sent  = 0;
    int stall_left  = 0;

    frame_delta_run_encoder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check each taken word, then pick next cycle's ready
    // mostly ready, short stalls now and then, rarely a long one
    initial begin
        int r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser, m_tlast);
            if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_tready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    m_tready   <= 1'b0;
                end else begin
                    stall_left = $urandom_range(9, 29);
                    m_tready   <= 1'b0;
                end
            end
        end
    end

    // sender gap ahead of a word: often none, mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one position and hold it until taken; tvalid stays up between
    // back-to-back words
    task automatic send_word(input logic [7:0] old_b, input logic [7:0] new_b, input bit eop);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {new_b, old_b};
        s_tlast  <= eop;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(old_b, new_b, eop);
        words_sent++;
    endtask

    // stop sending and let every queued stream word come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_words.size() != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic write_rotate(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_rotate(v);
        cfg_valid <= 1'b0;
    endtask

    // one page built from alternating stretches of equal and differing bytes,
    // with some fully random positions mixed in; last position ends the page
    task automatic run_page(input int len, input bit long_eq);
        int         i;
        int         seg_left;
        bit         seg_diff;
        logic [7:0] old_b;
        logic [7:0] new_b;
        seg_left = 0;
        seg_diff = 1'b1;
        for (i = 0; i < len; i++) begin
            if (seg_left == 0) begin
                seg_diff = !seg_diff;
                if (seg_diff)
                    seg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 64)
                                                          : $urandom_range(1, 8);
                else if (long_eq)
                    seg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 450)
                                                          : $urandom_range(5, 60);
                else
                    seg_left = $urandom_range(1, 5);
            end
            seg_left--;
            old_b = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                new_b = 8'($urandom);
            else if (seg_diff)
                new_b = old_b ^ 8'($urandom_range(1, 255));
            else
                new_b = old_b;
            send_word(old_b, new_b, i == len - 1);
        end
    endtask

    // a page made only of differing bytes, ending on the last of them
    task automatic long_run_page(input int n);
        int         i;
        logic [7:0] old_b;
        for (i = 0; i < n; i++) begin
            old_b = 8'($urandom);
            send_word(old_b, ~old_b, i == n - 1);
        end
    endtask

    // pages of random length, the last one cut so that exactly n words go out
    task automatic random_phase(input int n);
        int stop_at;
        int len;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            // now and then hold off until the stream is empty
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(61, 200)
                                              : $urandom_range(1, 60);
            if (len > stop_at - words_sent)
                len = stop_at - words_sent;
            run_page(len, $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_rotate(1'b0);

        // equal position, no word out
        send_word(8'h00, 8'h00, 1'b0);
        // two-byte run with the byte extremes, closed by an equal position
        send_word(8'h00, 8'hff, 1'b0);
        send_word(8'hff, 8'h00, 1'b0);
        send_word(8'ha5, 8'ha5, 1'b0);
        // run open at end of page gets flushed before the terminator
        send_word(8'h12, 8'h34, 1'b1);
        // end of page with nothing open: terminator only
        send_word(8'h7e, 8'h7e, 1'b1);
        send_word(8'hff, 8'hff, 1'b0);
        send_word(8'h01, 8'hfe, 1'b0);
        send_word(8'h80, 8'h7f, 1'b1);
        wait_drained();

        // aux plane coding on data bytes
        write_rotate(1'b1);
        send_word(8'h00, 8'h01, 1'b0);
        send_word(8'h00, 8'h80, 1'b0);
        send_word(8'h00, 8'hf0, 1'b0);
        send_word(8'h00, 8'h0f, 1'b0);
        send_word(8'h33, 8'h33, 1'b1);

        // run split at the maximum length, exactly at end of page and past it
        long_run_page(MaxRun);
        long_run_page(MaxRun + 1);
        random_phase(45);
        wait_drained();

        // full-rate stretch
        write_rotate(1'b0);
        no_idle = 1'b1;
        random_phase(40);
        no_idle = 1'b0;
        wait_drained();

        write_rotate(1'b1);
        random_phase(40);
        wait_drained();

        write_rotate(1'b0);
        random_phase(40);
        wait_drained();

        sb.flush_missing();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
